FILE: design/evad_pkg.sv
`default_nettype none

package evad_pkg;

  // Default for the largest chunk; a chunk that reaches it closes on its own.
  localparam int unsigned CHUNK_SAMPLES_MAX_DEF = 1024;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned RUN_W    = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_THRESHOLD = 2'd0,
    CFG_SPEECH_TO_START = 2'd1,
    CFG_SILENCE_TO_STOP = 2'd2
  } evad_cfg_idx_e;

  localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 16'd500;
  localparam logic [RUN_W-1:0]   SPEECH_TO_START_RST = 8'd3;
  localparam logic [RUN_W-1:0]   SILENCE_TO_STOP_RST = 8'd10;
  localparam logic [RUN_W-1:0]   RUN_MAX             = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } evad_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic launch;     // load the divider
    logic from_pend;  // load it from the held chunk instead of the closing one
    logic step;       // one quotient bit
    logic finish;     // update run counters and result register
  } evad_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic close_fire; // a transfer closes the current chunk
    logic pend;       // a closed chunk waits for the divider
    logic div_last;   // the divider is on its final bit
  } evad_sts_t;

endpackage

`default_nettype wire

FILE: design/evad_ctrl.sv
`default_nettype none

module evad_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  evad_pkg::evad_sts_t   sts_i,
  input  wire                   out_ready_i,
  output evad_pkg::evad_cmd_t   cmd_o,
  output logic                  out_valid_o
);
  import evad_pkg::*;

  evad_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.pend) begin
          cmd_o.launch    = 1'b1;
          cmd_o.from_pend = 1'b1;
          state_d         = ST_DIV;
        end else if (sts_i.close_fire) begin
          cmd_o.launch = 1'b1;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/evad_dp.sv
`default_nettype none

module evad_dp #(
  parameter int unsigned ChunkSamplesMax = evad_pkg::CHUNK_SAMPLES_MAX_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  evad_pkg::evad_cmd_t                   cmd_i,
  output evad_pkg::evad_sts_t                   sts_o,
  input  wire                                   cfg_we_i,
  input  wire  [evad_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [evad_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  signed [evad_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire                                   chunk_end_i,
  output logic [evad_pkg::LEVEL_W-1:0]          mean_level_o,
  output logic                                  chunk_is_speech_o,
  output logic                                  speaking_o,
  output logic                                  speech_started_o,
  output logic                                  speech_stopped_o
);
  import evad_pkg::*;

  localparam int unsigned CntW  = $clog2(ChunkSamplesMax + 1);
  localparam int unsigned SumW  = CntW + SAMPLE_W - 1;
  localparam int unsigned StepW = $clog2(SumW);
  localparam logic [CntW-1:0]  CntMax   = CntW'(ChunkSamplesMax);
  localparam logic [StepW-1:0] StepLast = StepW'(SumW - 1);

  // Configuration registers
  logic [LEVEL_W-1:0] thr_q;
  logic [RUN_W-1:0]   start_cnt_q, stop_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= LEVEL_THRESHOLD_RST;
      start_cnt_q <= SPEECH_TO_START_RST;
      stop_cnt_q  <= SILENCE_TO_STOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEVEL_THRESHOLD: thr_q       <= cfg_data_i[LEVEL_W-1:0];
        CFG_SPEECH_TO_START: start_cnt_q <= cfg_data_i[RUN_W-1:0];
        CFG_SILENCE_TO_STOP: stop_cnt_q  <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accumulator
  logic [SumW-1:0]     sum_q, sum_inc, pend_sum_q;
  logic [CntW-1:0]     cnt_q, cnt_inc, pend_cnt_q;
  logic                pend_q;
  logic [SAMPLE_W-1:0] mag;
  logic                fire, closing;

  assign mag        = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign sum_inc    = sum_q + SumW'(mag);
  assign cnt_inc    = cnt_q + 1'b1;
  assign in_ready_o = !pend_q;
  assign fire       = in_valid_i && in_ready_o;
  assign closing    = chunk_end_i || (cnt_inc == CntMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (fire) begin
        sum_q <= closing ? '0 : sum_inc;
        cnt_q <= closing ? '0 : cnt_inc;
      end
      // Hold a closed chunk while the divider or the output is still busy with the last one
      if (fire && closing && !cmd_i.launch) begin
        pend_q <= 1'b1;
      end else if (cmd_i.launch && cmd_i.from_pend) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && closing && !cmd_i.launch) begin
      pend_sum_q <= sum_inc;
      pend_cnt_q <= cnt_inc;
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [SumW-1:0]  dq_q;
  logic [CntW-1:0]  div_q, rem_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    trial, diff;
  logic             ge;

  assign trial = {rem_q, dq_q[SumW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.launch) begin
      dq_q   <= cmd_i.from_pend ? pend_sum_q : sum_inc;
      div_q  <= cmd_i.from_pend ? pend_cnt_q : cnt_inc;
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.step) begin
      dq_q   <= {dq_q[SumW-2:0], ge};
      rem_q  <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
      step_q <= step_q + 1'b1;
    end
  end

  assign sts_o.close_fire = fire && closing;
  assign sts_o.pend       = pend_q;
  assign sts_o.div_last   = (step_q == StepLast);

  // Run counters and speaking state
  logic [LEVEL_W-1:0] mean;
  logic               is_speech, start, stop, spk_mid;
  logic [RUN_W-1:0]   speech_run_q, silence_run_q, speech_run_d, silence_run_d;
  logic               speaking_q;

  assign mean      = dq_q[LEVEL_W-1:0];
  assign is_speech = mean > thr_q;

  always_comb begin
    if (is_speech) begin
      speech_run_d  = (speech_run_q == RUN_MAX) ? RUN_MAX : speech_run_q + 1'b1;
      silence_run_d = '0;
    end else begin
      silence_run_d = (silence_run_q == RUN_MAX) ? RUN_MAX : silence_run_q + 1'b1;
      speech_run_d  = '0;
    end
    start   = !speaking_q && (speech_run_d >= start_cnt_q);
    spk_mid = speaking_q || start;
    stop    = spk_mid && (silence_run_d >= stop_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speech_run_q  <= '0;
      silence_run_q <= '0;
      speaking_q    <= 1'b0;
    end else if (cmd_i.finish) begin
      speech_run_q  <= stop ? '0 : speech_run_d;
      silence_run_q <= silence_run_d;
      speaking_q    <= spk_mid && !stop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mean_level_o      <= mean;
      chunk_is_speech_o <= is_speech;
      speaking_o        <= spk_mid && !stop;
      speech_started_o  <= start;
      speech_stopped_o  <= stop;
    end
  end

endmodule

`default_nettype wire

FILE: design/energy_voice_activity_detector.sv
// Energy-threshold voice activity detector.
// Input channel: one signed 16-bit sample per transfer with a chunk_end flag
// marking the last sample of a chunk. A chunk that reaches ChunkSamplesMax
// samples closes on that sample regardless of the flag.
// Output channel: one transfer per closed chunk with the truncated mean
// absolute level, the speech decision, the speaking state and start/stop
// events. Nothing is produced for the other samples.
// Throughput: one sample per cycle while no chunk is held. At chunk close,
// the sum and count go to a restoring divider that makes one quotient bit per
// cycle, SumW bits in all (26 at the default chunk size), while the next chunk
// keeps accumulating.
// If a second chunk closes while the divider or the output is still busy,
// that chunk is held and in_ready_o drops until the divider takes it.
// A receiver stall holds the result; accumulation goes on unless a chunk is held.
// Reset clears the accumulator, run counters and speaking state and loads
// the register defaults (threshold 500, start 3, stop 10).
// Configuration writes take effect at once; write only while idle.
`default_nettype none

module energy_voice_activity_detector #(
  parameter int unsigned ChunkSamplesMax = evad_pkg::CHUNK_SAMPLES_MAX_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [evad_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [evad_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  signed [evad_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire                                   chunk_end_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [evad_pkg::LEVEL_W-1:0]          mean_level_o,
  output logic                                  chunk_is_speech_o,
  output logic                                  speaking_o,
  output logic                                  speech_started_o,
  output logic                                  speech_stopped_o
);
  import evad_pkg::*;

  evad_cmd_t cmd;
  evad_sts_t sts;

  // Sequence: launch the divider, step it, update the decision, present
  evad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .out_valid_o (out_valid_o)
  );

  // Accumulator, held chunk, divider, run counters and result register
  evad_dp #(
    .ChunkSamplesMax (ChunkSamplesMax)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .chunk_end_i       (chunk_end_i),
    .mean_level_o      (mean_level_o),
    .chunk_is_speech_o (chunk_is_speech_o),
    .speaking_o        (speaking_o),
    .speech_started_o  (speech_started_o),
    .speech_stopped_o  (speech_stopped_o)
  );

  // A start that is not undone on the same chunk leaves the block speaking
  a_start_speaking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speech_started_o && !speech_stopped_o |-> speaking_o)
    else $error("start event without speaking state");

  // A stop always leaves the block silent
  a_stop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speech_stopped_o |-> !speaking_o)
    else $error("stop event with speaking state");

  // No new sample closes a chunk while another closed chunk is held
  a_no_double_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.close_fire |-> !sts.pend)
    else $error("chunk closed while one is held");

  // A direct launch only takes a chunk that closes in this cycle
  a_launch_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.launch && !cmd.from_pend |-> sts.close_fire)
    else $error("divider launched without a closing chunk");

  // A held chunk is launched as soon as the controller is idle
  a_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pend && !out_valid_o && !cmd.step && !cmd.finish |-> cmd.launch)
    else $error("held chunk not launched when divider is free");

endmodule

`default_nettype wire
